>>> src/lfe_pkg.sv
// Shared types and constants for the RGB LED fade engine.
package lfe_pkg;

  localparam int LED_COUNT = 8;
  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int IDX_W     = (LED_W > 3) ? LED_W : 3;
  localparam int SEL_CMP_W = 7;

  localparam logic [7:0]  TICK_MILLIS_RST = 8'd10;
  localparam logic [15:0] STEP_MAX        = 16'hFFFF;
  localparam logic [7:0]  POS_TOP         = 8'hFF;
  localparam logic        ACT_TICK        = 1'b0;
  localparam logic        ACT_START       = 1'b1;

  // red in [7:0], green in [15:8], blue in [23:16]
  typedef logic [23:0] color_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TICK,
    ST_MIX,
    ST_PUT
  } lfe_state_t;

endpackage

>>> src/lfe_div.sv
// Bit-serial restoring divider for the fade step, 65535*tick_millis/duration.
module lfe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  tick_millis,
  input  logic [15:0] duration,
  output logic        done,
  output logic [15:0] step
);
  import lfe_pkg::*;

  logic [23:0] dq;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;

  logic [16:0] rem_sh;
  logic [17:0] trial;
  logic        qbit;

  always_comb begin
    rem_sh = {rem[15:0], dq[23]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs};
    qbit   = ~trial[17];
  end

  // quotient above 16 bits saturates
  assign step = (dq[23:16] != 8'd0) ? STEP_MAX : dq[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd24;
        dq   <= {tick_millis, 16'h0000} - {16'h0000, tick_millis};
        rem  <= 17'd0;
        dvs  <= duration;
      end else if (busy) begin
        rem  <= qbit ? trial[16:0] : rem_sh;
        dq   <= {dq[22:0], qbit};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/lfe_mix.sv
// Bit-serial blend of current and target color, all channels at once.
module lfe_mix (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [7:0]      pos,
  input  lfe_pkg::color_t cur,
  input  lfe_pkg::color_t tgt,
  output logic            done,
  output lfe_pkg::color_t res
);
  import lfe_pkg::*;

  logic [7:0]  pm;
  logic [7:0]  qm;
  logic [15:0] cur_sh [3];
  logic [15:0] tgt_sh [3];
  logic [15:0] acc_c  [3];
  logic [15:0] acc_t  [3];
  logic [3:0]  cnt;
  logic        busy;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c*8 +: 8] = acc_c[c][15:8] + acc_t[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd8;
        pm   <= pos;
        qm   <= 8'(9'd256 - {1'b0, pos});
        for (int c = 0; c < 3; c++) begin
          cur_sh[c] <= {8'h00, cur[c*8 +: 8]};
          tgt_sh[c] <= {8'h00, tgt[c*8 +: 8]};
          acc_c[c]  <= 16'd0;
          acc_t[c]  <= 16'd0;
        end
      end else if (busy) begin
        // add the shifted operand for the low multiplier bit, then advance
        for (int c = 0; c < 3; c++) begin
          acc_c[c]  <= acc_c[c] + (qm[0] ? cur_sh[c] : 16'd0);
          acc_t[c]  <= acc_t[c] + (pm[0] ? tgt_sh[c] : 16'd0);
          cur_sh[c] <= {cur_sh[c][14:0], 1'b0};
          tgt_sh[c] <= {tgt_sh[c][14:0], 1'b0};
        end
        qm  <= {1'b0, qm[7:1]};
        pm  <= {1'b0, pm[7:1]};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/rgb_led_fade_engine_unit.sv
// Top level of the RGB LED fade engine: fader state, sequencer and stream ports.
//
// Input transactions on s_axis carry one item. tuser = 0 is a tick, tuser = 1
// starts a fade on the LED given in tdata with a target color and a duration.
// A start yields no output. Its step is found by a bit-serial divider, so a
// start with nonzero duration holds the block until the divider is done; a
// zero duration sets the maximum step at once.
// A tick walks the LEDs in order and emits one m_axis transaction per LED,
// tlast marking the final LED, tuser the done flag. An LED that is not at
// its start or target is blended by a bit-serial multiply; one that is takes
// its start or target color directly. One item is worked at a time;
// s_axis_tready is high only between items. The result register holds a
// finished color while the next item is accepted; if the receiver stalls,
// the walk waits on that register.
// cfg_wr_en writes tick_millis (reset 10); the user must assert it only while idle, as the block does not enforce it.
// Reset (rst, synchronous) clears all colors, positions and steps to zero.
module rgb_led_fade_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // led_select[2:0], target_red[10:3], target_green[18:11], target_blue[26:19],
  // fade_duration[42:27], zero fill
  input  logic [47:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_number[2:0], red_level[10:3], green_level[18:11], blue_level[26:19], zero fill
  output logic [31:0] m_axis_tdata,
  // fade_done[0]
  output logic        m_axis_tuser,
  // last_of_run
  output logic        m_axis_tlast
);
  import lfe_pkg::*;

  logic [7:0]  tick_millis;
  color_t      cur_mem   [LED_COUNT];
  color_t      start_mem [LED_COUNT];
  color_t      tgt_mem   [LED_COUNT];
  logic [15:0] pos_mem   [LED_COUNT];
  logic [15:0] step_mem  [LED_COUNT];

  lfe_state_t  state, state_next;
  logic [IDX_W-1:0] li;
  color_t      res_color;
  logic        res_done;

  logic [2:0]  in_sel;
  color_t      in_tgt;
  logic [15:0] in_dur;
  logic        in_fire;
  logic        sel_ok;

  logic        div_start, div_done;
  logic [15:0] div_step;
  logic        mix_start, mix_done;
  color_t      mix_res;
  logic        put_en;
  logic        out_free;
  logic        li_last;

  logic [LED_W-1:0] ia;
  logic [15:0] pos_cur;
  logic [7:0]  p_top;
  logic [16:0] pos_sum;
  logic [15:0] pos_sat;

  assign in_sel   = s_axis_tdata[2:0];
  assign in_tgt   = s_axis_tdata[26:3];
  assign in_dur   = s_axis_tdata[42:27];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign sel_ok   = SEL_CMP_W'(in_sel) < SEL_CMP_W'(LED_COUNT);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign li_last  = (li == IDX_W'(LED_COUNT - 1));

  assign ia      = li[LED_W-1:0];
  assign pos_cur = pos_mem[ia];
  assign p_top   = pos_cur[15:8];
  assign pos_sum = {1'b0, pos_cur} + {1'b0, step_mem[ia]};
  assign pos_sat = pos_sum[16] ? STEP_MAX : pos_sum[15:0];

  lfe_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .tick_millis (tick_millis),
    .duration    (in_dur),
    .done        (div_done),
    .step        (div_step)
  );

  lfe_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .pos   (p_top),
    .cur   (cur_mem[ia]),
    .tgt   (tgt_mem[ia]),
    .done  (mix_done),
    .res   (mix_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == ACT_TICK) begin
            state_next = ST_TICK;
          end else if (sel_ok && in_dur != 16'd0) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (p_top == POS_TOP || p_top == 8'd0) state_next = ST_PUT;
        else state_next = ST_MIX;
      end
      ST_MIX: begin
        if (mix_done) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) state_next = li_last ? ST_IDLE : ST_TICK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mix_start     = 1'b0;
    put_en        = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = in_fire && s_axis_tuser == ACT_START && sel_ok && in_dur != 16'd0;
      end
      ST_TICK: mix_start = !(p_top == POS_TOP || p_top == 8'd0);
      ST_PUT:  put_en    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_millis   <= TICK_MILLIS_RST;
      li            <= '0;
      m_axis_tvalid <= 1'b0;
      for (int n = 0; n < LED_COUNT; n++) begin
        cur_mem[n]   <= '0;
        start_mem[n] <= '0;
        tgt_mem[n]   <= '0;
        pos_mem[n]   <= '0;
        step_mem[n]  <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) tick_millis <= cfg_wr_data;

      if (state == ST_IDLE && in_fire) begin
        if (s_axis_tuser == ACT_TICK) begin
          li <= '0;
        end else if (sel_ok) begin
          // arm the fader; the step comes now or when the divider finishes
          li <= IDX_W'(in_sel);
          start_mem[in_sel[LED_W-1:0]] <= cur_mem[in_sel[LED_W-1:0]];
          tgt_mem[in_sel[LED_W-1:0]]   <= in_tgt;
          pos_mem[in_sel[LED_W-1:0]]   <= 16'd0;
          if (in_dur == 16'd0) step_mem[in_sel[LED_W-1:0]] <= STEP_MAX;
        end
      end

      if (state == ST_DIV && div_done) step_mem[ia] <= div_step;

      if (state == ST_TICK) begin
        res_done  <= (p_top == POS_TOP);
        res_color <= (p_top == POS_TOP) ? tgt_mem[ia] : start_mem[ia];
      end
      if (state == ST_MIX && mix_done) res_color <= mix_res;

      if (put_en) begin
        cur_mem[ia] <= res_color;
        if (!res_done) pos_mem[ia] <= pos_sat;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {5'd0, res_color, li[2:0]};
        m_axis_tuser  <= res_done;
        m_axis_tlast  <= li_last;
        if (!li_last) li <= li + IDX_W'(1);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
